/* hw/rtl/wpc_pkg.sv */
// Shared constants, types and widths for the walk path counter.
package wpc_pkg;

   // Field widths of the request and response words.
   localparam int unsigned POS_W   = 10;
   localparam int unsigned STEP_W  = 11;
   localparam int unsigned WAYS_W  = 30;

   // Default longest walk the cell row can model.
   localparam int unsigned MAX_STEPS_DEF = 1024;

   // Modulus of every count.
   localparam logic [WAYS_W-1:0] WALK_PRIME = 30'd1000000007;

   // Control that the sequencer broadcasts along the cell row.
   typedef struct packed {
      logic load;
      logic step;
   } wpc_ctl_type;

endpackage

/* hw/rtl/walk_path_count_mod.sv */
// Top level of the walk path counter: request sequencer, cell row and response register.
//
//  Channel | Ports                                        | Direction
//  --------+----------------------------------------------+----------
//  req     | req_valid, req_ready, req_start_pos,          | in
//          | req_end_pos, req_step_count                  |
//  rsp     | rsp_valid, rsp_ready, rsp_ways               | out
//
// After acceptance of a word the sequencer loads the row, steps the cell row once
// for each of min(step_count, MAX_STEPS) steps, captures the result, hands it
// over and returns to idle; only then is the next request word taken.
// The walk is seeded at the offset end minus start mirrored about the center
// cell, so the answer is read from the center cell, or is zero when out of reach.
// Reset is synchronous and clears the sequencer; the row is loaded afresh for
// every word. A stalled response holds the block until it is taken.
module walk_path_count_mod
   import wpc_pkg::*;
#(
   parameter int unsigned MAX_STEPS = MAX_STEPS_DEF
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [POS_W-1:0]  req_start_pos,
   input  logic [POS_W-1:0]  req_end_pos,
   input  logic [STEP_W-1:0] req_step_count,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [WAYS_W-1:0] rsp_ways
);

   localparam int unsigned KMAX   = (MAX_STEPS < 2047) ? MAX_STEPS : 2047;
   localparam int unsigned CNT_W  = $clog2(KMAX + 1);
   localparam int unsigned SEED_W = $clog2(2 * MAX_STEPS + 1024) + 1;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_LOAD = 4'b0010,
      ST_RUN  = 4'b0100,
      ST_RESP = 4'b1000
   } state_type;

   state_type                 state_ff, state_in;
   logic [CNT_W-1:0]          steps_left_ff, steps_left_in;
   logic signed [SEED_W-1:0]  seed_ff, seed_in;
   logic                      reach_ff, reach_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [WAYS_W-1:0]         rsp_ways_ff, rsp_ways_in;

   logic                      req_fire;
   logic [CNT_W-1:0]          k_sat;
   logic [POS_W-1:0]          adist;
   logic [WAYS_W-1:0]         center_count;
   wpc_ctl_type               row_ctl;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;

   // Saturate the step count and find the distance between the positions.
   assign k_sat = (req_step_count > STEP_W'(KMAX)) ? CNT_W'(KMAX) : CNT_W'(req_step_count);
   assign adist = (req_end_pos >= req_start_pos) ? (req_end_pos - req_start_pos)
                                                 : (req_start_pos - req_end_pos);

   // Sequencer: load the row, step it, then present the center cell, or zero when out of reach.
   always_comb begin
      state_in      = state_ff;
      steps_left_in = steps_left_ff;
      seed_in       = seed_ff;
      reach_in      = reach_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_ways_in   = rsp_ways_ff;
      row_ctl.load  = 1'b0;
      row_ctl.step  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               steps_left_in = k_sat;
               seed_in       = SEED_W'(MAX_STEPS) + SEED_W'(req_start_pos)
                               - SEED_W'(req_end_pos);
               reach_in      = ({2'b00, adist} <= 12'(k_sat));
               state_in      = ST_LOAD;
            end
         end
         ST_LOAD: begin
            row_ctl.load = 1'b1;
            state_in     = ST_RUN;
         end
         ST_RUN: begin
            if (steps_left_ff != '0) begin
               row_ctl.step  = 1'b1;
               steps_left_in = steps_left_ff - CNT_W'(1);
            end else begin
               rsp_ways_in  = reach_ff ? center_count : '0;
               rsp_valid_in = 1'b1;
               state_in     = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
            state_in     = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         steps_left_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         steps_left_ff <= steps_left_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      seed_ff     <= seed_in;
      reach_ff    <= reach_in;
      rsp_ways_ff <= rsp_ways_in;
   end

   wpc_row #(
      .MAX_STEPS (MAX_STEPS)
   ) u_row (
      .clock        (clock),
      .ctl          (row_ctl),
      .seed_idx     (seed_ff),
      .center_count (center_count)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_ways  = rsp_ways_ff;

endmodule

/* hw/rtl/wpc_cell.sv */
// One cell of the walk row: holds the count for one offset and updates it.
module wpc_cell
   import wpc_pkg::*;
(
   input  logic              clock,
   input  wpc_ctl_type       ctl,
   input  logic              seed_hit,
   input  logic [WAYS_W-1:0] left_count,
   input  logic [WAYS_W-1:0] right_count,
   output logic [WAYS_W-1:0] count
);

   logic [WAYS_W-1:0] count_ff;
   logic [WAYS_W-1:0] count_in;
   logic [WAYS_W:0]   sum;

   // Sum of both neighbors, folded back below the prime once.
   assign sum = {1'b0, left_count} + {1'b0, right_count};

   always_comb begin
      count_in = count_ff;
      if (ctl.load) begin
         count_in = seed_hit ? WAYS_W'(1) : '0;
      end else if (ctl.step) begin
         if (sum >= {1'b0, WALK_PRIME}) begin
            count_in = WAYS_W'(sum - {1'b0, WALK_PRIME});
         end else begin
            count_in = sum[WAYS_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
   end

   assign count = count_ff;

endmodule

/* hw/rtl/wpc_row.sv */
// Row of walk cells, each taking the sum of its two neighbors on every step.
module wpc_row
   import wpc_pkg::*;
#(
   parameter int unsigned MAX_STEPS = MAX_STEPS_DEF
)
(
   input  logic                                              clock,
   input  wpc_ctl_type                                       ctl,
   input  logic signed [$clog2(2*MAX_STEPS+1024):0]          seed_idx,
   output logic [WAYS_W-1:0]                                 center_count
);

   localparam int unsigned CELLS  = 2 * MAX_STEPS + 1;
   localparam int unsigned SEED_W = $clog2(2 * MAX_STEPS + 1024) + 1;

   logic [WAYS_W-1:0] count [CELLS];

   genvar i;
   generate
      for (i = 0; i < CELLS; i++) begin : g_cell
         logic [WAYS_W-1:0] left_count;
         logic [WAYS_W-1:0] right_count;
         logic              seed_hit;

         // Cells beyond either end of the row read as zero.
         if (i == 0) begin : g_lo
            assign left_count = '0;
         end else begin : g_lo_n
            assign left_count = count[i-1];
         end
         if (i == CELLS - 1) begin : g_hi
            assign right_count = '0;
         end else begin : g_hi_n
            assign right_count = count[i+1];
         end

         // The walk is seeded where the target offset maps onto the center.
         assign seed_hit = (seed_idx == $signed(SEED_W'(i)));

         wpc_cell u_cell (
            .clock       (clock),
            .ctl         (ctl),
            .seed_hit    (seed_hit),
            .left_count  (left_count),
            .right_count (right_count),
            .count       (count[i])
         );
      end
   endgenerate

   assign center_count = count[MAX_STEPS];

endmodule

/* tb/walk_path_count_mod_tb.sv */
// Self-checking testbench for the walk path counter: random and directed queries, scoreboard.
module walk_path_count_mod_tb
   import wpc_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned     MAX_STEPS    = MAX_STEPS_DEF;
   localparam longint unsigned WALK_MOD     = WALK_PRIME;
   localparam int unsigned     RANDOM_WORDS = 580;
   localparam int unsigned     LIMIT_CYCLES = 4000000;

   // Expected response of one accepted query, kept with the query for messages.
   typedef struct {
      logic [POS_W-1:0]  start_pos;
      logic [POS_W-1:0]  end_pos;
      logic [STEP_W-1:0] step_count;
      logic [WAYS_W-1:0] ways;
   } walk_query_type;

   // Scoreboard: counts walks as binomial coefficients and matches them in order.
   class walk_count_board;
      longint unsigned fact [0:MAX_STEPS];
      longint unsigned inv_fact [0:MAX_STEPS];
      walk_query_type  ways_q [$];
      int unsigned     errors = 0;

      function new();
         longint unsigned base;
         longint unsigned acc;
         int unsigned     expo;
         fact[0] = 1;
         for (int i = 1; i <= MAX_STEPS; i++) fact[i] = fact[i-1] * i % WALK_MOD;
         // Inverse of the largest factorial by Fermat, then walk down.
         acc  = 1;
         base = fact[MAX_STEPS];
         expo = WALK_MOD - 2;
         while (expo != 0) begin
            if (expo & 1) acc = acc * base % WALK_MOD;
            base = base * base % WALK_MOD;
            expo = expo >> 1;
         end
         inv_fact[MAX_STEPS] = acc;
         for (int i = MAX_STEPS; i > 0; i--) inv_fact[i-1] = inv_fact[i] * i % WALK_MOD;
      endfunction

      // Walks of k steps with net offset d number C(k, (k+d)/2) when reachable.
      function logic [WAYS_W-1:0] count_walks(logic [POS_W-1:0] from_pos,
                                              logic [POS_W-1:0] to_pos,
                                              logic [STEP_W-1:0] steps);
         int              reach;
         int              net_offset;
         int              adist;
         int              rights;
         longint unsigned c;
         reach      = (steps > MAX_STEPS) ? MAX_STEPS : int'(steps);
         net_offset = int'(to_pos) - int'(from_pos);
         adist      = (net_offset < 0) ? -net_offset : net_offset;
         if (adist > reach || ((reach - adist) % 2) != 0) return '0;
         rights = (reach + net_offset) / 2;
         c = fact[reach] * inv_fact[rights] % WALK_MOD;
         c = c * inv_fact[reach - rights] % WALK_MOD;
         return c[WAYS_W-1:0];
      endfunction

      function void note_query(logic [POS_W-1:0] from_pos, logic [POS_W-1:0] to_pos,
                               logic [STEP_W-1:0] steps);
         walk_query_type q;
         q.start_pos  = from_pos;
         q.end_pos    = to_pos;
         q.step_count = steps;
         q.ways       = count_walks(from_pos, to_pos, steps);
         ways_q.push_back(q);
      endfunction

      function int unsigned pending();
         return ways_q.size();
      endfunction

      task report(string msg);
         $display("ERROR @%0t: %s", $time, msg);
         errors++;
      endtask

      task check_ways(logic [WAYS_W-1:0] got);
         walk_query_type q;
         if (ways_q.size() == 0) begin
            report($sformatf("response word ways=%0d with no query outstanding", got));
            return;
         end
         q = ways_q.pop_front();
         if (got !== q.ways)
            report($sformatf("start=%0d end=%0d steps=%0d: ways=%0d, want %0d",
                             q.start_pos, q.end_pos, q.step_count, got, q.ways));
      endtask
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [POS_W-1:0]  req_start_pos = '0;
   logic [POS_W-1:0]  req_end_pos = '0;
   logic [STEP_W-1:0] req_step_count = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [WAYS_W-1:0] rsp_ways;

   walk_count_board sb;
   bit              steady = 1'b0;
   int unsigned     cycles = 0;

   walk_path_count_mod #(
      .MAX_STEPS(MAX_STEPS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_start_pos(req_start_pos),
      .req_end_pos(req_end_pos),
      .req_step_count(req_step_count),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_ways(rsp_ways)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Response side stalls at random outside the steady stretch.
   always @(negedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= 14);
   end

   // Every accepted response word is checked against the oldest query.
   always @(posedge clock) begin
      if (!reset && sb != null && rsp_valid === 1'b1 && rsp_ready === 1'b1)
         sb.check_ways(rsp_ways);
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles", cycles);
         $display("simulation failed");
         $finish;
      end
   end

   // Offers one query word, with an optional gap, and returns at the falling edge after it.
   task send_query(input logic [POS_W-1:0] from_pos, input logic [POS_W-1:0] to_pos,
                   input logic [STEP_W-1:0] steps);
      int unsigned gap_max;
      if (!steady && $urandom_range(99) < 14) begin
         gap_max = ((steps > 60) ? 60 : steps) + 4;
         req_valid <= 1'b0;
         repeat ($urandom_range(1, gap_max)) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_start_pos  <= from_pos;
      req_end_pos    <= to_pos;
      req_step_count <= steps;
      do @(posedge clock); while (req_ready !== 1'b1);
      sb.note_query(from_pos, to_pos, steps);
      @(negedge clock);
   endtask

   // Holds the request side off until every outstanding response has arrived.
   task drain_responses();
      req_valid <= 1'b0;
      do @(negedge clock); while (sb.pending() != 0);
   endtask

   // Mostly reachable walks of short length, some long or saturated, some unreachable.
   task send_random_query();
      int unsigned kind;
      int unsigned pick;
      int          steps;
      int          reach;
      int          net_offset;
      int          lo;
      int          hi;
      int          from_pos;
      pick = $urandom_range(99);
      if (pick < 82)      steps = $urandom_range(0, 40);
      else if (pick < 95) steps = $urandom_range(41, 300);
      else if (pick < 98) steps = $urandom_range(301, MAX_STEPS);
      else                steps = $urandom_range(MAX_STEPS + 1, 2047);
      reach = (steps > MAX_STEPS) ? MAX_STEPS : steps;
      kind  = $urandom_range(99);
      if (kind < 86) begin
         net_offset = 2 * int'($urandom_range(0, reach)) - reach;
         // A wrong-parity target for part of the noise.
         if (kind >= 72) net_offset = (net_offset > 0) ? net_offset - 1 : net_offset + 1;
         if (net_offset > 1023) net_offset -= 2;
         if (net_offset < -1023) net_offset += 2;
         lo = (net_offset < 0) ? -net_offset : 0;
         hi = (net_offset > 0) ? 1023 - net_offset : 1023;
         from_pos = $urandom_range(lo, hi);
         send_query(POS_W'(from_pos), POS_W'(from_pos + net_offset), STEP_W'(steps));
      end else begin
         send_query(POS_W'($urandom_range(0, 1023)), POS_W'($urandom_range(0, 1023)),
                    STEP_W'(steps));
      end
   endtask

   initial begin
      sb = new();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed words: zero steps, single steps, extremes, saturation, unreachable, parity.
      send_query(10'd0, 10'd0, 11'd0);
      send_query(10'd7, 10'd8, 11'd0);
      send_query(10'd1023, 10'd1023, 11'd0);
      send_query(10'd300, 10'd301, 11'd1);
      send_query(10'd300, 10'd299, 11'd1);
      send_query(10'd0, 10'd1, 11'd1);
      send_query(10'd1023, 10'd1023, 11'd2);
      send_query(10'd0, 10'd1023, 11'd1023);
      send_query(10'd1023, 10'd0, 11'd1023);
      send_query(10'd0, 10'd1022, 11'd1024);
      send_query(10'd512, 10'd512, 11'd1024);
      send_query(10'd500, 10'd500, 11'd2047);
      send_query(10'd3, 10'd5, 11'd1025);
      send_query(10'd0, 10'd1023, 11'd2000);
      send_query(10'd0, 10'd1023, 11'd10);
      send_query(10'd5, 10'd6, 11'd4);
      send_query(10'd600, 10'd580, 11'd40);
      send_query(10'd341, 10'd682, 11'd1365);
      drain_responses();

      // Random words, with a stretch that never idles and a full drain partway.
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         steady = (n >= 250 && n < 360);
         if (n == 100) drain_responses();
         send_random_query();
      end
      steady = 1'b0;
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (MAX_STEPS + 8) @(posedge clock);
      if (sb.errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

/* walk_path_count_mod.f */
hw/rtl/wpc_pkg.sv
hw/rtl/wpc_cell.sv
hw/rtl/wpc_row.sv
hw/rtl/walk_path_count_mod.sv
tb/walk_path_count_mod_tb.sv
